[hdl/pl0ts_pkg.sv]
// pl0ts_pkg: shared types, token and error codes, keyword table and helpers
// for the pl0 token scanner; depends on nothing
package pl0ts_pkg;

  localparam int MaxDigitsDef = 5;
  localparam int MaxIdentDef  = 11;
  localparam int WordSlots    = 16;   // longest word still counted
  localparam int LenW         = 5;    // holds 0..WordSlots
  localparam int IdentSlots   = 11;   // characters that reach the result fields
  localparam int IdxW         = $clog2(IdentSlots);
  localparam int NumW         = 17;
  localparam int KwCount      = 15;
  localparam int KwMaxLen     = 9;
  localparam int QDepth       = 4;
  localparam int QPtrW        = $clog2(QDepth);
  localparam int QCntW        = $clog2(QDepth + 1);

  // token codes
  localparam logic [5:0] TK_ERROR   = 6'd0;
  localparam logic [5:0] TK_IDENT   = 6'd2;
  localparam logic [5:0] TK_NUMBER  = 6'd3;
  localparam logic [5:0] TK_PLUS    = 6'd4;
  localparam logic [5:0] TK_MINUS   = 6'd5;
  localparam logic [5:0] TK_TIMES   = 6'd6;
  localparam logic [5:0] TK_SLASH   = 6'd7;
  localparam logic [5:0] TK_EQL     = 6'd9;
  localparam logic [5:0] TK_NEQ     = 6'd10;
  localparam logic [5:0] TK_LSS     = 6'd11;
  localparam logic [5:0] TK_LEQ     = 6'd12;
  localparam logic [5:0] TK_GTR     = 6'd13;
  localparam logic [5:0] TK_GEQ     = 6'd14;
  localparam logic [5:0] TK_LPAREN  = 6'd15;
  localparam logic [5:0] TK_RPAREN  = 6'd16;
  localparam logic [5:0] TK_COMMA   = 6'd17;
  localparam logic [5:0] TK_SEMI    = 6'd18;
  localparam logic [5:0] TK_PERIOD  = 6'd19;
  localparam logic [5:0] TK_BECOMES = 6'd20;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NUM_LONG = 3'd1;
  localparam logic [2:0] ERR_ID_LONG  = 3'd2;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd3;
  localparam logic [2:0] ERR_COLON    = 3'd4;

  // characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;

  // keywords, first character in the highest used byte
  localparam logic [8*KwMaxLen-1:0] KW_TEXT [KwCount] = '{
    "nul", "odd", "begin", "end", "if", "then", "while", "do",
    "call", "const", "var", "procedure", "write", "read", "else"};
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd3, 4'd3, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2,
    4'd4, 4'd5, 4'd3, 4'd9, 4'd5, 4'd4, 4'd4};
  localparam logic [5:0] KW_CODE [KwCount] = '{
    6'd1, 6'd8, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26,
    6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33};

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [16:0] number_value;
    logic [63:0] ident_chars_low;
    logic [23:0] ident_chars_high;
    logic [3:0]  ident_length;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  item0;
    out_item_t  item1;
  } q_push_t;

  typedef struct packed {
    logic not_empty;
    logic room_for_two;
  } q_stat_t;

  typedef enum logic [4:0] {
    PEND_NONE  = 5'b00001,
    PEND_LT    = 5'b00010,
    PEND_GT    = 5'b00100,
    PEND_COLON = 5'b01000,
    PEND_SLASH = 5'b10000
  } pend_t;

  typedef enum logic [3:0] {
    CM_CODE  = 4'b0001,
    CM_LINE  = 4'b0010,
    CM_BLOCK = 4'b0100,
    CM_STAR  = 4'b1000
  } cmode_t;

  function automatic out_item_t simple_item(logic [5:0] kind, logic [2:0] err);
    out_item_t it;
    it            = '0;
    it.token_kind = kind;
    it.error_code = err;
    return it;
  endfunction

  // single-character operators, zero for anything else
  function automatic logic [5:0] single_op(logic [7:0] c);
    logic [5:0] k;
    case (c)
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      CH_STAR:   k = TK_TIMES;
      CH_EQ:     k = TK_EQL;
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_COMMA:  k = TK_COMMA;
      CH_SEMI:   k = TK_SEMI;
      CH_PERIOD: k = TK_PERIOD;
      default:   k = TK_ERROR;
    endcase
    return k;
  endfunction

endpackage

[hdl/pl0ts_if.sv]
// pl0ts_if: valid/ready channel interfaces of the pl0 token scanner
// character items in, token items out; no dependencies
interface pl0ts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface pl0ts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [2:0]  error_code;
  logic [16:0] number_value;
  logic [63:0] ident_chars_low;
  logic [23:0] ident_chars_high;
  logic [3:0]  ident_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output error_code, output number_value,
                  output ident_chars_low, output ident_chars_high, output ident_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_code, input number_value,
                input ident_chars_low, input ident_chars_high, input ident_length,
                input last_of_run, output ready);
endinterface

[hdl/pl0_token_scanner_top.sv]
// pl0_token_scanner_top: pl0 lexical scanner, one character item in, token items out
// uses pl0ts_pkg, pl0ts_if, pl0ts_word_class and pl0ts_out_queue
//
// usage
//   in_ch takes one ascii character per item plus an end_of_text flag on the
//   last character of a text; out_res gives token items (code 1..33, or 0 with
//   an error code), at most two per character, last_of_run marking the final
//   one caused by a character
//   a character is scanned in the cycle it is accepted: word state, pending
//   operator and comment state update at that edge and its token items enter a
//   four-entry result queue, whose registered head slot drives out_res
//   throughput is one character per cycle; in_ch.ready drops only while the
//   queue has fewer than two free entries, which happens when out_res is held
//   or when several characters in a row each give two items
//   a stalled receiver sees its item held steady until taken, and input backs up as above
//   rst_n (synchronous, active low) empties the queue, clears the word, drops
//   any pending operator and leaves comment mode; no clearing pass is needed
//   end_of_text flushes the open word and pending operator, drops an open
//   comment and returns the scanner to its reset state for the next text
module pl0_token_scanner_top #(
  parameter int MAX_DIGITS      = pl0ts_pkg::MaxDigitsDef,
  parameter int MAX_IDENT_CHARS = pl0ts_pkg::MaxIdentDef
) (
  input logic         clk,
  input logic         rst_n,
  pl0ts_in_if.sink    in_ch,
  pl0ts_out_if.source out_res
);
  import pl0ts_pkg::*;

  localparam int AccW = $clog2(10 ** MAX_DIGITS);

  // word state
  logic [IdentSlots-1:0][7:0] word_bytes_r, word_bytes_nxt;
  logic [LenW-1:0]            word_len_r, word_len_nxt;
  logic                       all_digits_r, all_digits_nxt;
  logic                       overflow_r, overflow_nxt;
  logic [AccW-1:0]            accum_r, accum_nxt;
  pend_t                      pend_r, pend_nxt;
  cmode_t                     cmode_r, cmode_nxt;

  // word after this character is appended, before any flush
  logic [IdentSlots-1:0][7:0] bytes_app;
  logic [LenW-1:0]            len_app;
  logic                       digits_app;
  logic                       ovf_app;
  logic [AccW-1:0]            accum_app;

  logic       accept;
  logic [7:0] c;
  logic       last;
  logic       is_digit, is_alpha, is_space;
  logic       scanning, consumed, rest, word_char, flush_scan, other;
  logic [5:0] op_code;
  pend_t      pend_scan;
  cmode_t     cm_scan;

  // candidate items in model order: pending operator, word, character, end flush
  out_item_t  a_item, w_item, c_item, e_item;
  logic       a_valid, w_valid, c_valid, e_valid;
  out_item_t  res0, res1;
  logic [1:0] n_res;

  q_push_t    push;
  q_stat_t    stat;
  out_item_t  head;

  assign accept = in_ch.valid && in_ch.ready;
  assign c      = in_ch.ch;
  assign last   = in_ch.end_of_text;

  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign scanning = (cmode_r == CM_CODE);

  // pending two-character operator and comment tracking
  always_comb begin
    consumed = 1'b0;
    a_valid  = 1'b0;
    a_item   = simple_item(TK_ERROR, ERR_NONE);
    cm_scan  = cmode_r;
    if (scanning) begin
      case (pend_r)
        PEND_SLASH: begin
          if (c == CH_SLASH) begin
            consumed = 1'b1;
            cm_scan  = CM_LINE;
          end else if (c == CH_STAR) begin
            consumed = 1'b1;
            cm_scan  = CM_BLOCK;
          end else begin
            a_valid = 1'b1;
            a_item  = simple_item(TK_SLASH, ERR_NONE);
          end
        end
        PEND_LT: begin
          a_valid = 1'b1;
          if (c == CH_EQ) begin
            consumed = 1'b1;
            a_item   = simple_item(TK_LEQ, ERR_NONE);
          end else if (c == CH_GT) begin
            consumed = 1'b1;
            a_item   = simple_item(TK_NEQ, ERR_NONE);
          end else begin
            a_item = simple_item(TK_LSS, ERR_NONE);
          end
        end
        PEND_GT: begin
          a_valid = 1'b1;
          if (c == CH_EQ) begin
            consumed = 1'b1;
            a_item   = simple_item(TK_GEQ, ERR_NONE);
          end else begin
            a_item = simple_item(TK_GTR, ERR_NONE);
          end
        end
        PEND_COLON: begin
          a_valid = 1'b1;
          if (c == CH_EQ) begin
            consumed = 1'b1;
            a_item   = simple_item(TK_BECOMES, ERR_NONE);
          end else begin
            a_item = simple_item(TK_ERROR, ERR_COLON);
          end
        end
        default: ;
      endcase
    end else begin
      case (cmode_r)
        CM_LINE: begin
          if (c == CH_LF) cm_scan = CM_CODE;
        end
        CM_BLOCK: begin
          if (c == CH_STAR) cm_scan = CM_STAR;
        end
        CM_STAR: begin
          if (c == CH_SLASH) cm_scan = CM_CODE;
          else if (c != CH_STAR) cm_scan = CM_BLOCK;
        end
        default: ;
      endcase
    end
  end

  // what the character itself does once any pending operator is settled
  assign rest       = scanning && !consumed;
  assign word_char  = rest && (is_digit || is_alpha);
  assign flush_scan = rest && !word_char && (word_len_r != '0);
  assign other      = rest && !word_char && !is_space;
  assign op_code    = single_op(c);

  always_comb begin
    c_valid   = 1'b0;
    c_item    = simple_item(TK_ERROR, ERR_NONE);
    pend_scan = scanning ? PEND_NONE : pend_r;
    if (other) begin
      if (op_code != TK_ERROR) begin
        c_valid = 1'b1;
        c_item  = simple_item(op_code, ERR_NONE);
      end else if (c == CH_LT) begin
        pend_scan = PEND_LT;
      end else if (c == CH_GT) begin
        pend_scan = PEND_GT;
      end else if (c == CH_COLON) begin
        pend_scan = PEND_COLON;
      end else if (c == CH_SLASH) begin
        pend_scan = PEND_SLASH;
      end else begin
        c_valid = 1'b1;
        c_item  = simple_item(TK_ERROR, ERR_BAD_CHAR);
      end
    end
  end

  // append a letter or digit; the value builds only while the word is all digits
  always_comb begin
    bytes_app  = word_bytes_r;
    len_app    = word_len_r;
    digits_app = all_digits_r;
    ovf_app    = overflow_r;
    accum_app  = accum_r;
    if (word_char) begin
      if (word_len_r < LenW'(WordSlots)) begin
        if (word_len_r < LenW'(IdentSlots)) bytes_app[word_len_r[IdxW-1:0]] = c;
        if (is_digit && all_digits_r && (int'(word_len_r) < MAX_DIGITS)) begin
          accum_app = AccW'({accum_r, 3'b000}) + AccW'({accum_r, 1'b0}) + AccW'(c[3:0]);
        end
        len_app = word_len_r + LenW'(1);
      end else begin
        ovf_app = 1'b1;
      end
      if (is_alpha) digits_app = 1'b0;
    end
  end

  pl0ts_word_class #(
    .MAX_DIGITS     (MAX_DIGITS),
    .MAX_IDENT_CHARS(MAX_IDENT_CHARS)
  ) u_word_class (
    .word_bytes(bytes_app),
    .word_len  (len_app),
    .all_digits(digits_app),
    .overflow  (ovf_app),
    .accum     (accum_app),
    .item      (w_item)
  );

  // the word ends on a separator or at end of text
  assign w_valid = flush_scan || (last && (len_app != '0));
  assign e_valid = last && (pend_scan != PEND_NONE);

  always_comb begin
    case (pend_scan)
      PEND_SLASH: e_item = simple_item(TK_SLASH, ERR_NONE);
      PEND_LT:    e_item = simple_item(TK_LSS, ERR_NONE);
      PEND_GT:    e_item = simple_item(TK_GTR, ERR_NONE);
      PEND_COLON: e_item = simple_item(TK_ERROR, ERR_COLON);
      default:    e_item = simple_item(TK_ERROR, ERR_NONE);
    endcase
  end

  // pack the (at most two) live candidates in order
  always_comb begin
    out_item_t  cand [4];
    logic [3:0] cand_v;
    cand[0] = a_item;
    cand[1] = w_item;
    cand[2] = c_item;
    cand[3] = e_item;
    cand_v  = {e_valid, c_valid, w_valid, a_valid};
    n_res   = 2'd0;
    res0    = simple_item(TK_ERROR, ERR_NONE);
    res1    = simple_item(TK_ERROR, ERR_NONE);
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (n_res == 2'd0) res0 = cand[i];
        else res1 = cand[i];
        n_res = n_res + 2'd1;
      end
    end
    res0.last_of_run = (n_res == 2'd1);
    res1.last_of_run = 1'b1;
  end

  // next state: a flushed word or end of text clears the word
  always_comb begin
    word_bytes_nxt = bytes_app;
    if (last || flush_scan) begin
      word_len_nxt   = '0;
      all_digits_nxt = 1'b1;
      overflow_nxt   = 1'b0;
      accum_nxt      = '0;
    end else begin
      word_len_nxt   = len_app;
      all_digits_nxt = digits_app;
      overflow_nxt   = ovf_app;
      accum_nxt      = accum_app;
    end
    pend_nxt  = last ? PEND_NONE : pend_scan;
    cmode_nxt = last ? CM_CODE : cm_scan;
  end

  // buffer bytes are only read below the word length, so no reset
  always_ff @(posedge clk) begin
    if (accept) word_bytes_r <= word_bytes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_len_r   <= '0;
      all_digits_r <= 1'b1;
      overflow_r   <= 1'b0;
      accum_r      <= '0;
      pend_r       <= PEND_NONE;
      cmode_r      <= CM_CODE;
    end else if (accept) begin
      word_len_r   <= word_len_nxt;
      all_digits_r <= all_digits_nxt;
      overflow_r   <= overflow_nxt;
      accum_r      <= accum_nxt;
      pend_r       <= pend_nxt;
      cmode_r      <= cmode_nxt;
    end
  end

  assign push.n     = accept ? n_res : 2'd0;
  assign push.item0 = res0;
  assign push.item1 = res1;

  pl0ts_out_queue u_out_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (out_res.valid && out_res.ready),
    .head (head),
    .stat (stat)
  );

  // room for the worst case of two items from the next character
  assign in_ch.ready = stat.room_for_two;

  assign out_res.valid            = stat.not_empty;
  assign out_res.token_kind       = head.token_kind;
  assign out_res.error_code       = head.error_code;
  assign out_res.number_value     = head.number_value;
  assign out_res.ident_chars_low  = head.ident_chars_low;
  assign out_res.ident_chars_high = head.ident_chars_high;
  assign out_res.ident_length     = head.ident_length;
  assign out_res.last_of_run      = head.last_of_run;

endmodule

[hdl/pl0ts_word_class.sv]
// pl0ts_word_class: turns a finished word into a number, keyword or identifier item
// uses pl0ts_pkg
module pl0ts_word_class #(
  parameter int MAX_DIGITS      = pl0ts_pkg::MaxDigitsDef,
  parameter int MAX_IDENT_CHARS = pl0ts_pkg::MaxIdentDef,
  localparam int AccW           = $clog2(10 ** MAX_DIGITS)
) (
  input  logic [pl0ts_pkg::IdentSlots-1:0][7:0] word_bytes,
  input  logic [pl0ts_pkg::LenW-1:0]            word_len,
  input  logic                                  all_digits,
  input  logic                                  overflow,
  input  logic [AccW-1:0]                       accum,
  output pl0ts_pkg::out_item_t                  item
);
  import pl0ts_pkg::*;

  logic       kw_hit;
  logic [5:0] kw_code;

  // parallel compare against every keyword
  always_comb begin
    logic match;
    kw_hit  = 1'b0;
    kw_code = TK_ERROR;
    for (int i = 0; i < KwCount; i++) begin
      match = (word_len == LenW'(KW_LEN[i]));
      for (int k = 0; k < KwMaxLen; k++) begin
        if (k < int'(KW_LEN[i])) begin
          if (word_bytes[k] != KW_TEXT[i][8*(int'(KW_LEN[i])-1-k) +: 8]) match = 1'b0;
        end
      end
      if (match && !kw_hit) begin
        kw_hit  = 1'b1;
        kw_code = KW_CODE[i];
      end
    end
  end

  always_comb begin
    item = simple_item(TK_ERROR, ERR_NONE);
    if (all_digits) begin
      if (overflow || int'(word_len) > MAX_DIGITS) begin
        item = simple_item(TK_ERROR, ERR_NUM_LONG);
      end else begin
        item              = simple_item(TK_NUMBER, ERR_NONE);
        item.number_value = NumW'(accum);
      end
    end else if (!overflow && kw_hit) begin
      item = simple_item(kw_code, ERR_NONE);
    end else if (overflow || int'(word_len) > MAX_IDENT_CHARS) begin
      item = simple_item(TK_ERROR, ERR_ID_LONG);
    end else begin
      item              = simple_item(TK_IDENT, ERR_NONE);
      item.ident_length = word_len[3:0];
      for (int k = 0; k < IdentSlots; k++) begin
        if (k < int'(word_len)) begin
          if (k < 8) item.ident_chars_low[8*k +: 8] = word_bytes[k];
          else item.ident_chars_high[8*(k-8) +: 8] = word_bytes[k];
        end
      end
    end
  end

endmodule

[hdl/pl0ts_out_queue.sv]
// pl0ts_out_queue: small result queue that takes up to two items per cycle
// and hands out one; uses pl0ts_pkg
module pl0ts_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pl0ts_pkg::q_push_t   push,
  input  logic                 pop,
  output pl0ts_pkg::out_item_t head,
  output pl0ts_pkg::q_stat_t   stat
);
  import pl0ts_pkg::*;

  out_item_t         slot_r [QDepth];
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QCntW-1:0]  count_r, count_nxt;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r + QPtrW'(pop);
    wr_ptr_nxt = wr_ptr_r + QPtrW'(push.n);
    count_nxt  = count_r + QCntW'(push.n) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) slot_r[wr_ptr_r] <= push.item0;
    if (push.n == 2'd2) slot_r[wr_ptr_r + QPtrW'(1)] <= push.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head              = slot_r[rd_ptr_r];
  assign stat.not_empty    = (count_r != '0);
  assign stat.room_for_two = (count_r <= QCntW'(QDepth - 2));

endmodule

[hdl/pl0ts_checker.sv]
// pl0ts_checker: port-level checks for the pl0 token scanner, bound to the top level
// uses pl0ts_pkg and pl0_token_scanner_top
module pl0ts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  token_kind,
  input logic [2:0]  error_code,
  input logic [16:0] number_value,
  input logic [3:0]  ident_length,
  input logic        last_of_run
);
  import pl0ts_pkg::*;

  // a held item stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(error_code)
      && $stable(number_value) && $stable(ident_length) && $stable(last_of_run))
    else $error("result item changed while stalled");

  // error items and only error items carry an error code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((token_kind == TK_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match token kind");

  a_num_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (number_value != '0) |-> (token_kind == TK_NUMBER))
    else $error("number value on a non-number token");

  a_ident_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (ident_length != '0) |-> (token_kind == TK_IDENT))
    else $error("identifier length on a non-identifier token");

  // queue starts empty when reset releases
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result item visible right after reset");

endmodule

bind pl0_token_scanner_top pl0ts_checker u_pl0ts_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .token_kind  (out_res.token_kind),
  .error_code  (out_res.error_code),
  .number_value(out_res.number_value),
  .ident_length(out_res.ident_length),
  .last_of_run (out_res.last_of_run)
);
